FILE: hdl/brd_pkg.sv
package brd_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_LIMBS_DEF  = 256;
   localparam int VALUE_BITS_DEF = 256;

   // Field widths
   localparam int WORD_W       = 64;
   localparam int RADIX_W      = 9;
   localparam int COUNT_W      = 9;
   localparam int DIGIT_W      = 8;
   localparam int GROUP_DIGITS = 8;
   localparam int GROUP_W      = GROUP_DIGITS * DIGIT_W;
   localparam int GCOUNT_W     = 4;
   localparam int SLOT_W       = $clog2(GROUP_DIGITS);
   localparam int DIV_RES_W    = 2 * DIGIT_W;

   // Radix limits
   localparam int RADIX_MIN = 2;
   localparam int RADIX_MAX = 256;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_PACK,
      ST_FLUSH
   } state_type;

   // One byte step of long division: {rem, dividend} / divisor.
   // rem < divisor, so the quotient fits one byte. Returns {quotient, remainder}.
   function automatic logic [DIV_RES_W-1:0] div_byte(
      input logic [DIGIT_W-1:0] rem,
      input logic [DIGIT_W-1:0] dividend,
      input logic [RADIX_W-1:0] divisor
   );
      logic [RADIX_W:0]   r;
      logic [DIGIT_W-1:0] q;
      r = {2'b00, rem};
      q = '0;
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         r = {r[RADIX_W-1:0], dividend[i]};
         if (r >= {1'b0, divisor}) begin
            r    = r - {1'b0, divisor};
            q[i] = 1'b1;
         end
      end
      return {q, r[DIGIT_W-1:0]};
   endfunction

endpackage

FILE: hdl/big_endian_radix_decompose_core.sv
// Radix decomposition of an unsigned value into digits, most significant first.
//
// Request channel (req_*): one beat carries the value as four 64-bit words,
// the radix (2..256), the digit count (1..256) and the bit-output flag.
// The core stalls the request channel while a conversion is in progress.
// Response channel (rsp_*): ceil(count/8) beats, eight 8-bit digits each,
// earliest digit in bits 63:56, unused slots zero; rsp_last_group marks
// the final beat of a conversion.
//
// Operation: each digit is one pass of a shared byte divider over the bytes of
// the working value still in use, one byte per cycle; once the value has reached
// zero, each further digit is written as zero at once. Emission reads each digit
// from the digit memory (ST_READ), packs it into its slot (ST_PACK) and sends
// each full group or the final group as one response beat (ST_FLUSH).
//
// A stalled response holds its beat; the core then waits before loading the
// next beat. A new request is taken while the final beat still waits.
// Reset (synchronous) returns the sequencer to idle and drops rsp_valid.
module big_endian_radix_decompose_core #(
   parameter int MAX_LIMBS  = brd_pkg::MAX_LIMBS_DEF,
   parameter int VALUE_BITS = brd_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [brd_pkg::WORD_W-1:0]    req_value_word0,
   input  logic [brd_pkg::WORD_W-1:0]    req_value_word1,
   input  logic [brd_pkg::WORD_W-1:0]    req_value_word2,
   input  logic [brd_pkg::WORD_W-1:0]    req_value_word3,
   input  logic [brd_pkg::RADIX_W-1:0]   req_radix,
   input  logic [brd_pkg::COUNT_W-1:0]   req_limb_count,
   input  logic                          req_bit_output,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brd_pkg::GROUP_W-1:0]   rsp_digit_group,
   output logic [brd_pkg::GCOUNT_W-1:0]  rsp_group_count,
   output logic                          rsp_last_group
);
   import brd_pkg::*;

   localparam int NB = (VALUE_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam int VW = NB * DIGIT_W;
   localparam int BW = $clog2(NB);
   localparam int LW = $clog2(NB + 1);
   localparam int AW = $clog2(MAX_LIMBS);

   // Registers
   state_type              state_ff, state_in;
   logic [VW-1:0]          val_ff, val_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [LW-1:0]          newlen_ff, newlen_in;
   logic [BW-1:0]          idx_ff, idx_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic                   lead_ff, lead_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   bits_ff, bits_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [COUNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [GROUP_W-1:0]     group_ff, group_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [DIGIT_W-1:0]     rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GROUP_W-1:0]     rsp_group_ff, rsp_group_in;
   logic [GCOUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Digit memory
   logic [DIGIT_W-1:0]     digit_mem [MAX_LIMBS];

   // Datapath signals
   logic [4*WORD_W-1:0]    full_value;
   logic [DIGIT_W-1:0]     cur_byte;
   logic [DIV_RES_W-1:0]   div_res;
   logic [DIGIT_W-1:0]     quo;
   logic [DIGIT_W-1:0]     rmd;
   logic                   drop;
   logic                   empty;
   logic                   pass_end;
   logic [LW-1:0]          run_len;
   logic [DIGIT_W-1:0]     raw_digit;
   logic [DIGIT_W-1:0]     digit;
   logic                   mem_we;
   logic                   div_last;
   logic                   last_digit;
   logic                   out_free;
   logic [RADIX_W-1:0]     radix_clamp;
   logic [COUNT_W-1:0]     count_clamp;
   logic [GCOUNT_W-1:0]    gcount;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit_group = rsp_group_ff;
   assign rsp_group_count = rsp_count_ff;
   assign rsp_last_group  = rsp_last_ff;

   // Shared byte divider over the working value
   assign full_value = {req_value_word3, req_value_word2, req_value_word1, req_value_word0};
   assign cur_byte   = val_ff[idx_ff*DIGIT_W +: DIGIT_W];
   assign div_res    = div_byte(rem_ff, cur_byte, radix_ff);
   assign quo        = div_res[DIV_RES_W-1:DIGIT_W];
   assign rmd        = div_res[DIGIT_W-1:0];
   assign drop       = lead_ff && (quo == '0);
   assign empty      = (len_ff == '0);
   assign pass_end   = empty || (idx_ff == '0);
   assign run_len    = drop ? LW'(idx_ff) : newlen_ff;
   assign raw_digit  = empty ? '0 : rmd;
   assign digit      = bits_ff ? DIGIT_W'(raw_digit != '0) : raw_digit;
   assign mem_we     = (state_ff == ST_DIVIDE) && pass_end;
   assign div_last   = mem_we && (wr_ptr_ff == '0);

   // Emission helpers
   assign last_digit = (rd_ptr_ff == count_ff - 1'b1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign gcount     = (slot_ff == '0) ? GCOUNT_W'(GROUP_DIGITS) : GCOUNT_W'(slot_ff);

   // Request field clamping
   always_comb begin
      radix_clamp = req_radix;
      if (int'(req_radix) < RADIX_MIN) begin
         radix_clamp = RADIX_W'(RADIX_MIN);
      end else if (int'(req_radix) > RADIX_MAX) begin
         radix_clamp = RADIX_W'(RADIX_MAX);
      end
      count_clamp = req_limb_count;
      if (req_limb_count == '0) begin
         count_clamp = COUNT_W'(1);
      end else if (int'(req_limb_count) > MAX_LIMBS) begin
         count_clamp = COUNT_W'(MAX_LIMBS);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_PACK;
         end
         ST_PACK: begin
            if (last_digit || (&slot_ff)) state_in = ST_FLUSH;
            else state_in = ST_READ;
         end
         ST_FLUSH: begin
            if (out_free) state_in = last_digit ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      val_in       = val_ff;
      len_in       = len_ff;
      newlen_in    = newlen_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      lead_in      = lead_ff;
      radix_in     = radix_ff;
      bits_in      = bits_ff;
      count_in     = count_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      group_in     = group_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_group_in = rsp_group_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in    = VW'(full_value[VALUE_BITS-1:0]);
               len_in    = LW'(NB);
               newlen_in = LW'(NB);
               idx_in    = BW'(NB - 1);
               rem_in    = '0;
               lead_in   = 1'b1;
               radix_in  = radix_clamp;
               bits_in   = req_bit_output;
               count_in  = count_clamp;
               wr_ptr_in = count_clamp - 1'b1;
               rd_ptr_in = '0;
               slot_in   = '0;
            end
         end
         ST_DIVIDE: begin
            // one byte of the current pass; a zero value gives digit zero at once
            if (!empty) begin
               val_in[idx_ff*DIGIT_W +: DIGIT_W] = quo;
               rem_in    = rmd;
               lead_in   = drop;
               newlen_in = run_len;
               idx_in    = idx_ff - 1'b1;
            end
            if (pass_end) begin
               len_in    = empty ? '0 : run_len;
               newlen_in = empty ? '0 : run_len;
               idx_in    = BW'(run_len - 1'b1);
               rem_in    = '0;
               lead_in   = 1'b1;
               wr_ptr_in = wr_ptr_ff - 1'b1;
            end
         end
         ST_PACK: begin
            // place the digit in its slot, earliest at the top
            if (slot_ff == '0) group_in = '0;
            group_in[(GROUP_DIGITS - 1 - int'(slot_ff))*DIGIT_W +: DIGIT_W] = rd_data_ff;
            slot_in = slot_ff + 1'b1;
            // a full group keeps the pointer on its last digit until the beat goes out
            if (!last_digit && !(&slot_ff)) rd_ptr_in = rd_ptr_ff + 1'b1;
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_group_in = group_ff;
               rsp_count_in = gcount;
               rsp_last_in  = last_digit;
               if (!last_digit) rd_ptr_in = rd_ptr_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      len_ff       <= len_in;
      newlen_ff    <= newlen_in;
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      lead_ff      <= lead_in;
      radix_ff     <= radix_in;
      bits_ff      <= bits_in;
      count_ff     <= count_in;
      wr_ptr_ff    <= wr_ptr_in;
      rd_ptr_ff    <= rd_ptr_in;
      group_ff     <= group_in;
      slot_ff      <= slot_in;
      rsp_group_ff <= rsp_group_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Digit memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) digit_mem[AW'(wr_ptr_ff)] <= digit;
      rd_data_ff <= digit_mem[AW'(rd_ptr_ff)];
   end

   // Checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> len_ff <= LW'(NB))
      else $error("working length exceeds value bytes");

   a_idx_in_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && !empty) |-> LW'(idx_ff) < len_ff)
      else $error("divider byte index outside working length");

   a_rd_in_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PACK || state_ff == ST_FLUSH) |-> rd_ptr_ff < count_ff)
      else $error("digit read beyond count");

   a_gcount_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0 && rsp_count_ff <= GCOUNT_W'(GROUP_DIGITS)))
      else $error("group count out of range");

   a_flush_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && !out_free) |=> state_ff == ST_FLUSH)
      else $error("beat dropped while response stalled");

endmodule
